@@ hdl/hgat_pkg.sv @@
// Package for the hash group aggregate table.
// Holds field widths, status codes, slot layout and controller/datapath signal groups.
// Depends on nothing.
`default_nettype none
package hgat_pkg;

	localparam int KEY_W    = 32;
	localparam int SAMPLE_W = 16;
	localparam int CNT_W    = 32;
	localparam int SUM_W    = 48;
	localparam int IDX_W    = 10;
	localparam int FILL_W   = 11;
	localparam int STATUS_W = 3;

	localparam logic [FILL_W-1:0] MAX_FILL_RST = 11'd512;
	localparam logic [SUM_W-1:0]  SUM_POS_LIM  = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0]  SUM_NEG_LIM  = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [CNT_W-1:0]  CNT_LIM      = {CNT_W{1'b1}};

	typedef enum logic [STATUS_W-1:0] {
		ST_UPDATED   = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	// One stored slot of the table.
	typedef struct packed {
		logic                       valid;
		logic [KEY_W-1:0]           key;
		logic [CNT_W-1:0]           count;
		logic signed [SUM_W-1:0]    sum;
		logic signed [SAMPLE_W-1:0] min;
		logic signed [SAMPLE_W-1:0] max;
	} slot_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;      // capture an accepted transaction
		logic    set_addr;  // start probing at the home slot
		logic    rd;        // read the slot under the probe address
		logic    advance;   // step to the next slot
		logic    clr;       // write one empty slot of the clearing pass
		logic    write;     // write the new aggregate back
		logic    out_load;  // load the result register
		status_t code;      // status of the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic home_done;
		logic clr_last;
		logic lookup;
		logic empty;
		logic match;
		logic last_probe;
		logic has_room;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

@@ hdl/hgat_if.sv @@
// Handshake channels of the hash group aggregate table.
// Request and response interfaces with valid, ready and payload; uses hgat_pkg.
`default_nettype none
interface hgat_req_if
	import hgat_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [KEY_W-1:0]           key_hash;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, mode, key_hash, sample, input ready);
	modport sink (input valid, mode, key_hash, sample, output ready);
endinterface

interface hgat_rsp_if
	import hgat_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic [IDX_W-1:0]           slot_index;
	logic [CNT_W-1:0]           group_count;
	logic signed [SUM_W-1:0]    group_sum;
	logic signed [SAMPLE_W-1:0] group_min;
	logic signed [SAMPLE_W-1:0] group_max;

	modport source (output valid, status, slot_index, group_count, group_sum,
		group_min, group_max, input ready);
	modport sink (input valid, status, slot_index, group_count, group_sum,
		group_min, group_max, output ready);
endinterface
`default_nettype wire

@@ hdl/hgat_rem.sv @@
// Home slot unit: key hash modulo the table size.
// A mask for a power-of-two size, otherwise a registered reciprocal multiplication and remainder; uses hgat_pkg.
`default_nettype none
module hgat_rem
	import hgat_pkg::*;
#(
	parameter int SLOTS = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [KEY_W-1:0]             key,
	output logic      [$clog2(SLOTS)-1:0]     home,
	output logic                              done
);
	localparam int AW = $clog2(SLOTS);

	generate
		if ((SLOTS & (SLOTS - 1)) == 0) begin : g_mask
			logic [KEY_W-1:0] key_q;

			// The low bits of the key are the home slot.
			always_ff @(posedge clk) begin
				if (start) begin
					key_q <= key;
				end
			end
			assign home = key_q[AW-1:0];
			assign done = 1'b1;
		end else begin : g_recip
			localparam int MW = KEY_W + 1;
			localparam int PW = KEY_W + MW;
			localparam longint unsigned MAGIC =
				((64'd1 << (KEY_W + AW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
			localparam logic [MW-1:0] MAGIC_V = MW'(MAGIC);
			localparam logic [1:0] CNT_DONE = 2'd2;
			logic [KEY_W-1:0]   key_q;
			logic [PW-1:0]      prod_q;
			logic [MW-AW-1:0]   quo;
			logic [KEY_W-1:0]   rem;
			logic [AW-1:0]      r_q;
			logic [1:0]         cnt_q;

			// Quotient from the scaled reciprocal, then the remainder by one subtraction.
			always_comb begin
				quo = prod_q[PW-1:KEY_W+AW];
				rem = key_q - KEY_W'(quo) * KEY_W'(SLOTS);
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q <= CNT_DONE;
				end else if (start) begin
					cnt_q <= '0;
				end else if (cnt_q != CNT_DONE) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_q <= key;
				end else if (cnt_q == 2'd0) begin
					prod_q <= PW'(key_q) * PW'(MAGIC_V);
				end else if (cnt_q == 2'd1) begin
					r_q <= rem[AW-1:0];
				end
			end

			assign home = r_q;
			assign done = (cnt_q == CNT_DONE);
		end
	endgenerate
endmodule
`default_nettype wire

@@ hdl/hgat_ctrl.sv @@
// Controller of the hash group aggregate table.
// Sequences clearing, home slot, probing and result hand-off; uses hgat_pkg.
`default_nettype none
module hgat_ctrl
	import hgat_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HOME,
		S_READ,
		S_CHECK
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   emit;
	logic   wr;

	assign req_ready = (state_q == S_IDLE);

	// Command decode and next state.
	always_comb begin
		cmd      = '0;
		cmd.code = ST_NOT_FOUND;
		state_nx = state_q;
		emit     = 1'b0;
		wr       = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nx = S_HOME;
				end
			end
			S_HOME: begin
				if (sts.home_done) begin
					cmd.set_addr = 1'b1;
					state_nx     = S_READ;
				end
			end
			S_READ: begin
				cmd.rd   = 1'b1;
				state_nx = S_CHECK;
			end
			S_CHECK: begin
				if (sts.empty) begin
					emit = 1'b1;
					if (sts.lookup) begin
						cmd.code = ST_NOT_FOUND;
					end else if (sts.has_room) begin
						cmd.code = ST_INSERTED;
						wr       = 1'b1;
					end else begin
						cmd.code = ST_FULL;
					end
				end else if (sts.match) begin
					emit = 1'b1;
					if (sts.lookup) begin
						cmd.code = ST_FOUND;
					end else begin
						cmd.code = ST_UPDATED;
						wr       = 1'b1;
					end
				end else if (sts.last_probe) begin
					emit     = 1'b1;
					cmd.code = sts.lookup ? ST_NOT_FOUND : ST_FULL;
				end else begin
					cmd.advance = 1'b1;
					state_nx    = S_READ;
				end
				// The write and the result go together once the result register is free.
				if (emit && sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.write    = wr;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end
endmodule
`default_nettype wire

@@ hdl/hgat_dp.sv @@
// Datapath of the hash group aggregate table.
// Slot memory, probe address, aggregate arithmetic, occupancy and result register;
// uses hgat_pkg and hgat_rem.
`default_nettype none
module hgat_dp
	import hgat_pkg::*;
#(
	parameter int SLOTS = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [FILL_W-1:0]          cfg_data,
	input  wire logic                       in_mode,
	input  wire logic [KEY_W-1:0]           in_key,
	input  wire logic signed [SAMPLE_W-1:0] in_sample,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic [STATUS_W-1:0]             out_status,
	output logic [IDX_W-1:0]                out_slot,
	output logic [CNT_W-1:0]                out_count,
	output logic signed [SUM_W-1:0]         out_sum,
	output logic signed [SAMPLE_W-1:0]      out_min,
	output logic signed [SAMPLE_W-1:0]      out_max,
	input  wire cmd_t                       cmd,
	output sts_t                            sts
);
	localparam int AW = $clog2(SLOTS);
	localparam int OW = $clog2(SLOTS + 1);
	localparam int CW = (OW > FILL_W) ? OW : FILL_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

	slot_t mem [SLOTS];

	logic                       mode_q;
	logic [KEY_W-1:0]           key_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [AW-1:0]              addr_q;
	logic [AW-1:0]              probe_q;
	logic [AW-1:0]              clr_q;
	logic [OW-1:0]              occ_q;
	logic [FILL_W-1:0]          max_fill_q;
	slot_t                      rd_q;
	logic                       out_valid_q;
	logic [AW-1:0]              home;
	logic                       home_done;
	slot_t                      upd;
	slot_t                      agg;
	logic signed [SUM_W:0]      sum_ext;

	hgat_rem #(.SLOTS(SLOTS)) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load),
		.key    (in_key),
		.home   (home),
		.done   (home_done)
	);

	// Captured transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= in_mode;
			key_q    <= in_key;
			sample_q <= in_sample;
		end
	end

	// Probe address and probe count.
	always_ff @(posedge clk) begin
		if (cmd.set_addr) begin
			addr_q  <= home;
			probe_q <= '0;
		end else if (cmd.advance) begin
			addr_q  <= (addr_q == LAST_SLOT) ? '0 : addr_q + 1'b1;
			probe_q <= probe_q + 1'b1;
		end
	end

	// Clearing pass address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Fill limit register and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fill_q <= MAX_FILL_RST;
			occ_q      <= '0;
		end else begin
			if (cfg_we) begin
				max_fill_q <= cfg_data;
			end
			if (cmd.write && (cmd.code == ST_INSERTED)) begin
				occ_q <= occ_q + 1'b1;
			end
		end
	end

	// Slot memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem[clr_q] <= '0;
		end else if (cmd.write) begin
			mem[addr_q] <= agg;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[addr_q];
		end
	end

	// Update of a matching slot with saturating sum and count.
	always_comb begin
		sum_ext   = {rd_q.sum[SUM_W-1], rd_q.sum} + (SUM_W + 1)'(sample_q);
		upd       = rd_q;
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			upd.sum = sum_ext[SUM_W] ? SUM_NEG_LIM : SUM_POS_LIM;
		end else begin
			upd.sum = sum_ext[SUM_W-1:0];
		end
		upd.count = (rd_q.count == CNT_LIM) ? CNT_LIM : rd_q.count + 1'b1;
		upd.min   = (sample_q < rd_q.min) ? sample_q : rd_q.min;
		upd.max   = (sample_q > rd_q.max) ? sample_q : rd_q.max;
	end

	// Slot contents after this transaction.
	always_comb begin
		case (cmd.code)
			ST_INSERTED: begin
				agg.valid = 1'b1;
				agg.key   = key_q;
				agg.count = CNT_W'(1);
				agg.sum   = SUM_W'(sample_q);
				agg.min   = sample_q;
				agg.max   = sample_q;
			end
			ST_UPDATED: agg = upd;
			ST_FOUND:   agg = rd_q;
			default:    agg = '0;
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= cmd.code;
			out_count  <= agg.count;
			out_sum    <= agg.sum;
			out_min    <= agg.min;
			out_max    <= agg.max;
			if (agg.valid) begin
				out_slot <= IDX_W'(addr_q);
			end else begin
				out_slot <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// Status to the controller.
	always_comb begin
		sts.home_done  = home_done;
		sts.clr_last   = (clr_q == LAST_SLOT);
		sts.lookup     = mode_q;
		sts.empty      = !rd_q.valid;
		sts.match      = rd_q.valid && (rd_q.key == key_q);
		sts.last_probe = (probe_q == LAST_SLOT);
		sts.has_room   = (CW'(occ_q) < CW'(max_fill_q));
		sts.out_free   = !out_valid_q || out_ready;
	end

	// Occupancy never exceeds the store.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(occ_q) <= CW'(SLOTS))
		else $error("occupancy exceeds table size");

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// An insert happens only below the fill limit and into an empty slot.
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.write && cmd.code == ST_INSERTED) |-> (sts.has_room && sts.empty))
		else $error("insert without room");

	// After an insert the occupancy has grown by one.
	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.write && cmd.code == ST_INSERTED) |=> (occ_q == $past(occ_q) + 1'b1))
		else $error("occupancy not counted");
endmodule
`default_nettype wire

@@ hdl/hash_group_aggregate_table.sv @@
// Top level of the hash group aggregate table.
// Joins the controller and datapath to the channels; uses hgat_pkg, hgat_if, hgat_ctrl, hgat_dp.
//
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    mode, key_hash, sample
// rsp       out  valid/ready    status, slot_index, group_count, group_sum, group_min, group_max
// cfg       in   cfg_we         cfg_data (max_fill)
//
// An item is loaded and its home slot found, then each probed slot takes one read and one check;
// the home slot takes a reciprocal remainder when TABLE_SLOTS is not a power of two.
// After reset a clearing pass writes every slot, with req.ready low.
// One item is processed at a time; the result register holds a finished result while
// the next transaction is taken, and the block stalls only when a second result is ready.
`default_nettype none
module hash_group_aggregate_table
	import hgat_pkg::*;
#(
	parameter int TABLE_SLOTS = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [FILL_W-1:0] cfg_data,
	hgat_req_if.sink               req,
	hgat_rsp_if.source             rsp
);
	cmd_t cmd;
	sts_t sts;

	hgat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hgat_dp #(.SLOTS(TABLE_SLOTS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_mode    (req.mode),
		.in_key     (req.key_hash),
		.in_sample  (req.sample),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_status (rsp.status),
		.out_slot   (rsp.slot_index),
		.out_count  (rsp.group_count),
		.out_sum    (rsp.group_sum),
		.out_min    (rsp.group_min),
		.out_max    (rsp.group_max),
		.cmd        (cmd),
		.sts        (sts)
	);
endmodule
`default_nettype wire
